// ----- sv/cbr_pkg.sv -----
package cbr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_ACT    = 2'd0,
    OP_LOAD_WEIGHT = 2'd1,
    OP_LOAD_BIAS   = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_IN_CHANNELS = 3'd2,
    REG_NUM_FILTERS = 3'd3,
    REG_KERNEL_SIDE = 3'd4,
    REG_STRIDE_STEP = 3'd5,
    REG_OUT_WIDTH   = 3'd6,
    REG_OUT_HEIGHT  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHK1,
    ST_CHK2,
    ST_CHK3,
    ST_CHK4,
    ST_SETUP,
    ST_ADDR,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic chk0;
    logic chk1;
    logic chk2;
    logic chk3;
    logic chk4;
    logic setup;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic last;
    logic empty;
  } sts_t;

endpackage

// ----- sv/conv2d_bias_relu.sv -----
// a compute request passes the check states, SETUP, ADDR, RUN, DRAIN, BIAS and DONE; its
// result is shown in OUT; a flagged request goes from SETUP straight to DONE and one with
// no channels skips ADDR, RUN and DRAIN; loads give no result; one compute at a time, and
// input is ready again the cycle after the result transfer
// loads: one per cycle while idle
// rst (synchronous) sets the configuration registers to 1 and the controller to idle
module conv2d_bias_relu #(
  parameter int ACT_WORDS = 4096,
  parameter int WEIGHT_WORDS = 4096,
  parameter int MAX_FILTERS = 64,
  parameter int MAX_KERNEL = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [11:0]        store_index,
  input  logic signed [15:0] act_or_weight,
  input  logic signed [31:0] bias_value,
  input  logic [5:0]         req_filter,
  input  logic [11:0]        req_row,
  input  logic [11:0]        req_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        relu_value,
  output logic               range_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import cbr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, xfer;
  logic [12:0] in_width, in_height, out_width, out_height;
  logic [6:0] in_channels, num_filters;
  logic [1:0] kernel_side;
  logic [2:0] stride_step;

  assign in_ready = !busy;
  assign cfg_ready = 1'b1;
  assign xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width <= 13'd1;
      in_height <= 13'd1;
      in_channels <= 7'd1;
      num_filters <= 7'd1;
      kernel_side <= 2'd1;
      stride_step <= 3'd1;
      out_width <= 13'd1;
      out_height <= 13'd1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IN_WIDTH:    in_width <= cfg_data[12:0];
        REG_IN_HEIGHT:   in_height <= cfg_data[12:0];
        REG_IN_CHANNELS: in_channels <= cfg_data[6:0];
        REG_NUM_FILTERS: num_filters <= cfg_data[6:0];
        REG_KERNEL_SIDE: kernel_side <= cfg_data[1:0];
        REG_STRIDE_STEP: stride_step <= cfg_data[2:0];
        REG_OUT_WIDTH:   out_width <= cfg_data[12:0];
        REG_OUT_HEIGHT:  out_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  cbr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .start(xfer && (op_t'(operation) == OP_COMPUTE)),
    .out_ready(out_ready), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  cbr_dp #(
    .ACT_WORDS(ACT_WORDS), .WEIGHT_WORDS(WEIGHT_WORDS),
    .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL)
  ) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .load_act(xfer && (op_t'(operation) == OP_LOAD_ACT)),
    .load_weight(xfer && (op_t'(operation) == OP_LOAD_WEIGHT)),
    .load_bias(xfer && (op_t'(operation) == OP_LOAD_BIAS)),
    .store_index(store_index), .act_or_weight(act_or_weight), .bias_value(bias_value),
    .req_filter(req_filter), .req_row(req_row), .req_col(req_col),
    .in_width(in_width), .in_height(in_height), .in_channels(in_channels),
    .num_filters(num_filters), .kernel_side(kernel_side), .stride_step(stride_step),
    .out_width(out_width), .out_height(out_height),
    .relu_value(relu_value), .range_error(range_error)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> relu_value == 31'd0)
    else $error("flagged result not zero");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(relu_value))
    else $error("result dropped");

endmodule

// ----- sv/cbr_ctrl.sv -----
module cbr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          out_ready,
  input  cbr_pkg::sts_t sts,
  output cbr_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import cbr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_CHK0;
      ST_CHK0:  state_next = ST_CHK1;
      ST_CHK1:  state_next = ST_CHK2;
      ST_CHK2:  state_next = ST_CHK3;
      ST_CHK3:  state_next = ST_CHK4;
      ST_CHK4:  state_next = ST_SETUP;
      ST_SETUP: begin
        if (sts.bad) state_next = ST_DONE;
        else if (sts.empty) state_next = ST_BIAS;
        else state_next = ST_ADDR;
      end
      ST_ADDR:  state_next = ST_RUN;
      ST_RUN:   if (sts.last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_BIAS;
      ST_BIAS:  state_next = ST_DONE;
      ST_DONE:  state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.start = (state == ST_IDLE) && start;
    cmd.chk0 = (state == ST_CHK0);
    cmd.chk1 = (state == ST_CHK1);
    cmd.chk2 = (state == ST_CHK2);
    cmd.chk3 = (state == ST_CHK3);
    cmd.chk4 = (state == ST_CHK4);
    cmd.setup = (state == ST_SETUP);
    cmd.step = (state == ST_RUN);
    cmd.finish = (state == ST_DONE);
    busy = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
  end

endmodule

// ----- sv/cbr_dp.sv -----
module cbr_dp #(
  parameter int ACT_WORDS = 4096,
  parameter int WEIGHT_WORDS = 4096,
  parameter int MAX_FILTERS = 64,
  parameter int MAX_KERNEL = 3
) (
  input  logic                clk,
  input  cbr_pkg::cmd_t       cmd,
  output cbr_pkg::sts_t       sts,
  input  logic                load_act,
  input  logic                load_weight,
  input  logic                load_bias,
  input  logic [11:0]         store_index,
  input  logic signed [15:0]  act_or_weight,
  input  logic signed [31:0]  bias_value,
  input  logic [5:0]          req_filter,
  input  logic [11:0]         req_row,
  input  logic [11:0]         req_col,
  input  logic [12:0]         in_width,
  input  logic [12:0]         in_height,
  input  logic [6:0]          in_channels,
  input  logic [6:0]          num_filters,
  input  logic [1:0]          kernel_side,
  input  logic [2:0]          stride_step,
  input  logic [12:0]         out_width,
  input  logic [12:0]         out_height,
  output logic [30:0]         relu_value,
  output logic                range_error
);
  import cbr_pkg::*;

  localparam int AW = $clog2(ACT_WORDS);
  localparam int WW = $clog2(WEIGHT_WORDS);
  localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  logic signed [15:0] act_mem [ACT_WORDS];
  logic signed [15:0] wgt_mem [WEIGHT_WORDS];
  logic signed [31:0] bias_mem [MAX_FILTERS];

  logic [5:0]  f;
  logic [11:0] r, c;
  logic        bad;
  logic [15:0] y0, x0;
  logic [15:0] y_last, x_last;
  logic [25:0] plane;
  logic [31:0] a_span;
  logic [31:0] w_span;
  logic [31:0] w_base;
  logic [6:0]  ch;
  logic [1:0]  ky, kx;
  logic [31:0] a_row, a_addr, w_addr;
  logic        rd_ok, rd_ok_q, mul_ok;
  logic signed [15:0] a_q, w_q;
  logic signed [31:0] prod;
  logic signed [47:0] acc;
  logic signed [31:0] bias_q;
  logic signed [48:0] total;

  always_ff @(posedge clk) begin
    if (load_act && ({20'd0, store_index} < 32'(ACT_WORDS)))
      act_mem[AW'(store_index)] <= act_or_weight;
    if (load_weight && ({20'd0, store_index} < 32'(WEIGHT_WORDS)))
      wgt_mem[WW'(store_index)] <= act_or_weight;
    if (load_bias && ({20'd0, store_index} < 32'(MAX_FILTERS)))
      bias_mem[FW'(store_index)] <= bias_value;
  end

  // request check, split over the states CHK0 to CHK4
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      f <= req_filter;
      r <= req_row;
      c <= req_col;
    end
    if (cmd.chk0) begin
      bad <= ({1'b0, f} >= num_filters) || ({26'd0, f} >= 32'(MAX_FILTERS)) ||
             ({1'b0, r} >= out_height) || ({1'b0, c} >= out_width) ||
             (kernel_side == 2'd0) || ({30'd0, kernel_side} > 32'(MAX_KERNEL)) ||
             (stride_step == 3'd0);
      y0 <= {4'd0, r} * {13'd0, stride_step};
      x0 <= {4'd0, c} * {13'd0, stride_step};
      plane <= in_width * in_height;
      w_base <= {26'd0, f} * {25'd0, in_channels};
    end
    if (cmd.chk1) begin
      y_last <= y0 + 16'(kernel_side) - 16'd1;
      x_last <= x0 + 16'(kernel_side) - 16'd1;
      w_base <= 32'(w_base * kernel_side);
      w_span <= 32'(({26'd0, f} + 32'd1) * in_channels);
    end
    if (cmd.chk2) begin
      if ((y_last >= 16'(in_height)) || (x_last >= 16'(in_width))) bad <= 1'b1;
      a_span <= ({16'd0, y_last} * {19'd0, in_width}) + {16'd0, x_last};
      w_span <= 32'(w_span * kernel_side);
      w_base <= 32'(w_base * kernel_side);
    end
    if (cmd.chk3) begin
      a_span <= a_span + ({25'd0, in_channels - 7'd1} * {6'd0, plane});
      w_span <= 32'(w_span * kernel_side);
    end
    if (cmd.chk4) begin
      if (in_channels != 7'd0) begin
        if (a_span >= 32'(ACT_WORDS)) bad <= 1'b1;
        if (w_span > 32'(WEIGHT_WORDS)) bad <= 1'b1;
      end
    end
  end

  assign sts.bad = bad;
  assign sts.empty = (in_channels == 7'd0);
  assign sts.last = (ch == in_channels - 7'd1) && (ky == kernel_side - 2'd1) &&
                    (kx == kernel_side - 2'd1);

  assign a_addr = a_row + 32'(kx);
  assign rd_ok = (a_addr < 32'(ACT_WORDS)) && (w_addr < 32'(WEIGHT_WORDS));

  // window walk: one multiply-accumulate per cycle
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ch <= '0;
      ky <= '0;
      kx <= '0;
      a_row <= ({16'd0, y0} * {19'd0, in_width}) + {16'd0, x0};
      w_addr <= w_base;
    end
    if (cmd.step) begin
      w_addr <= w_addr + 32'd1;
      if (kx == kernel_side - 2'd1) begin
        kx <= '0;
        if (ky == kernel_side - 2'd1) begin
          ky <= '0;
          ch <= ch + 7'd1;
          a_row <= a_row + 32'(plane) - 32'(32'(kernel_side - 2'd1) * in_width);
        end else begin
          ky <= ky + 2'd1;
          a_row <= a_row + 32'(in_width);
        end
      end else begin
        kx <= kx + 2'd1;
      end
    end
    if (cmd.step) begin
      a_q <= act_mem[a_addr[AW-1:0]];
      w_q <= wgt_mem[w_addr[WW-1:0]];
    end
    rd_ok_q <= cmd.step && rd_ok;
    prod <= a_q * w_q;
    mul_ok <= rd_ok_q;
    if (cmd.setup) acc <= '0;
    else if (mul_ok) acc <= acc + 48'(prod);
    if (cmd.setup) bias_q <= bias_mem[FW'(f)];
    if (cmd.finish) begin
      range_error <= bad;
      if (bad || total < 0) relu_value <= '0;
      else if (total > 49'sh7FFFFFFF) relu_value <= 31'h7FFFFFFF;
      else relu_value <= total[30:0];
    end
  end

  assign total = 49'(acc) + 49'(bias_q);

endmodule
